// ===== design/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int unsigned HueWidth     = 11;
   localparam int unsigned ChannelWidth = 8;
   localparam int unsigned ProductWidth = 2 * ChannelWidth;
   localparam int unsigned SectorWidth  = HueWidth - ChannelWidth;

   localparam logic [ChannelWidth-1:0] FullScale = 8'd255;

   // Sector codes; six and seven are treated as the last sector.
   localparam logic [SectorWidth-1:0] SectorRedToYellow    = 3'd0;
   localparam logic [SectorWidth-1:0] SectorYellowToGreen  = 3'd1;
   localparam logic [SectorWidth-1:0] SectorGreenToCyan    = 3'd2;
   localparam logic [SectorWidth-1:0] SectorCyanToBlue     = 3'd3;
   localparam logic [SectorWidth-1:0] SectorBlueToMagenta  = 3'd4;

   typedef struct packed {
      logic [HueWidth-1:0]     hue;
      logic [ChannelWidth-1:0] saturation;
      logic [ChannelWidth-1:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic [ChannelWidth-1:0] red;
      logic [ChannelWidth-1:0] green;
      logic [ChannelWidth-1:0] blue;
   } rgb_type;

   // Valid bit and sector code that travel alongside the arithmetic.
   typedef struct packed {
      logic                   valid;
      logic [SectorWidth-1:0] sector;
   } stage_ctl_type;

   // Truncating division by 255 for any product of two 8-bit values.
   // x / 255 equals (x + 1 + x / 256) / 256 for every product of two 8-bit values.
   function automatic logic [ChannelWidth-1:0] div255(input logic [ProductWidth-1:0] x);
      logic [ProductWidth:0] sum;
      sum = {1'b0, x} + {{ProductWidth{1'b0}}, 1'b1}
            + {{(ChannelWidth+1){1'b0}}, x[ProductWidth-1:ChannelWidth]};
      return sum[ProductWidth-1:ChannelWidth];
   endfunction

endpackage

// ===== design/hsvrgb_sel.sv =====
`timescale 1ns / 1ps

module hsvrgb_sel (
   input  logic                                     clock,
   input  logic                                     reset,
   input  hsvrgb_pkg::stage_ctl_type                ctl,
   input  logic [hsvrgb_pkg::ProductWidth-1:0]      prod_q,
   input  logic [hsvrgb_pkg::ProductWidth-1:0]      prod_t,
   input  logic [hsvrgb_pkg::ChannelWidth-1:0]      p_val,
   input  logic [hsvrgb_pkg::ChannelWidth-1:0]      v_val,
   output logic                                     rsp_valid,
   output hsvrgb_pkg::rgb_type                      rsp_data
);

   logic [hsvrgb_pkg::ChannelWidth-1:0] q_val;
   logic [hsvrgb_pkg::ChannelWidth-1:0] t_val;
   hsvrgb_pkg::rgb_type                 rgb_in;
   hsvrgb_pkg::rgb_type                 rgb_ff;
   logic                                valid_ff;

   assign q_val = hsvrgb_pkg::div255(prod_q);
   assign t_val = hsvrgb_pkg::div255(prod_t);

   always_comb begin
      case (ctl.sector)
         hsvrgb_pkg::SectorRedToYellow: begin
            rgb_in = '{red: v_val, green: t_val, blue: p_val};
         end
         hsvrgb_pkg::SectorYellowToGreen: begin
            rgb_in = '{red: q_val, green: v_val, blue: p_val};
         end
         hsvrgb_pkg::SectorGreenToCyan: begin
            rgb_in = '{red: p_val, green: v_val, blue: t_val};
         end
         hsvrgb_pkg::SectorCyanToBlue: begin
            rgb_in = '{red: p_val, green: q_val, blue: v_val};
         end
         hsvrgb_pkg::SectorBlueToMagenta: begin
            rgb_in = '{red: t_val, green: p_val, blue: v_val};
         end
         default: begin
            rgb_in = '{red: v_val, green: p_val, blue: q_val};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.valid;
      end
      rgb_ff <= rgb_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rgb_ff;

endmodule

// ===== design/hsv_to_rgb_integer.sv =====
`timescale 1ns / 1ps

// Channel     Ports                        Transfer
// input       start, busy, req_data        start high and busy low at a rising edge
// result      rsp_valid, rsp_data          rsp_valid high for one cycle, always taken
//
// A colour is accepted every cycle; busy never rises.
// Each result is registered through two multiply stages, each followed by a
// divide-by-255 stage, with the sector selection in the last one.
// Reset clears the valid bits of all four stages; nothing else is held.
// The pipeline never stalls, since the receiver takes each result as it appears.

module hsv_to_rgb_integer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hsvrgb_pkg::hsv_type  req_data,
   output logic                 rsp_valid,
   output hsvrgb_pkg::rgb_type  rsp_data
);

   localparam int unsigned CW = hsvrgb_pkg::ChannelWidth;
   localparam int unsigned PW = hsvrgb_pkg::ProductWidth;

   // Stage 1: the three first-level products.
   hsvrgb_pkg::stage_ctl_type ctl1_ff, ctl1_in;
   logic [PW-1:0]             prod_sf_ff,  prod_sf_in;
   logic [PW-1:0]             prod_sfc_ff, prod_sfc_in;
   logic [PW-1:0]             prod_p_ff,   prod_p_in;
   logic [CW-1:0]             v1_ff;

   // Stage 2: complements of the scaled saturation, and p.
   hsvrgb_pkg::stage_ctl_type ctl2_ff;
   logic [CW-1:0]             qk_ff, qk_in;
   logic [CW-1:0]             tk_ff, tk_in;
   logic [CW-1:0]             p2_ff;
   logic [CW-1:0]             v2_ff;

   // Stage 3: products that give q and t.
   hsvrgb_pkg::stage_ctl_type ctl3_ff;
   logic [PW-1:0]             prod_q_ff, prod_q_in;
   logic [PW-1:0]             prod_t_ff, prod_t_in;
   logic [CW-1:0]             p3_ff;
   logic [CW-1:0]             v3_ff;

   logic [CW-1:0]             frac;

   assign busy = 1'b0;
   assign frac = req_data.hue[CW-1:0];

   always_comb begin
      ctl1_in.valid  = start;
      ctl1_in.sector = req_data.hue[hsvrgb_pkg::HueWidth-1:CW];
      prod_sf_in  = {{CW{1'b0}}, req_data.saturation} * {{CW{1'b0}}, frac};
      prod_sfc_in = {{CW{1'b0}}, req_data.saturation}
                    * {{CW{1'b0}}, hsvrgb_pkg::FullScale - frac};
      prod_p_in   = {{CW{1'b0}}, req_data.brightness}
                    * {{CW{1'b0}}, hsvrgb_pkg::FullScale - req_data.saturation};
   end

   assign qk_in = hsvrgb_pkg::FullScale - hsvrgb_pkg::div255(prod_sf_ff);
   assign tk_in = hsvrgb_pkg::FullScale - hsvrgb_pkg::div255(prod_sfc_ff);

   assign prod_q_in = {{CW{1'b0}}, v2_ff} * {{CW{1'b0}}, qk_ff};
   assign prod_t_in = {{CW{1'b0}}, v2_ff} * {{CW{1'b0}}, tk_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
      end else begin
         ctl1_ff.valid <= ctl1_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
         ctl3_ff.valid <= ctl2_ff.valid;
      end
      ctl1_ff.sector <= ctl1_in.sector;
      prod_sf_ff     <= prod_sf_in;
      prod_sfc_ff    <= prod_sfc_in;
      prod_p_ff      <= prod_p_in;
      v1_ff          <= req_data.brightness;

      ctl2_ff.sector <= ctl1_ff.sector;
      qk_ff          <= qk_in;
      tk_ff          <= tk_in;
      p2_ff          <= hsvrgb_pkg::div255(prod_p_ff);
      v2_ff          <= v1_ff;

      ctl3_ff.sector <= ctl2_ff.sector;
      prod_q_ff      <= prod_q_in;
      prod_t_ff      <= prod_t_in;
      p3_ff          <= p2_ff;
      v3_ff          <= v2_ff;
   end

   hsvrgb_sel u_sel (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl3_ff),
      .prod_q    (prod_q_ff),
      .prod_t    (prod_t_ff),
      .p_val     (p3_ff),
      .v_val     (v3_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/hsvrgb_checker.sv =====
`timescale 1ns / 1ps

module hsvrgb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input hsvrgb_pkg::hsv_type  req_data,
   input logic                 rsp_valid,
   input hsvrgb_pkg::rgb_type  rsp_data
);

   // The block takes a colour in every cycle.
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every transfer in gives exactly one result.
   assert property (@(posedge clock) disable iff (reset) start && !busy |-> ##4 rsp_valid)
      else $error("result missing after transfer");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(start, 4))
      else $error("result without a transfer");

   // With no saturation every channel carries the brightness.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.saturation, 4) == 8'd0 |->
         rsp_data.red == $past(req_data.brightness, 4) &&
         rsp_data.green == $past(req_data.brightness, 4) &&
         rsp_data.blue == $past(req_data.brightness, 4))
      else $error("grey colour converted wrongly");

   // Zero brightness gives black whatever the hue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.brightness, 4) == 8'd0 |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0)
      else $error("black converted wrongly");

endmodule

bind hsv_to_rgb_integer hsvrgb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_hsv_to_rgb_integer.sv =====
`timescale 1ns / 1ps

module tb_hsv_to_rgb_integer;

   localparam int unsigned CW          = hsvrgb_pkg::ChannelWidth;
   localparam int unsigned HW          = hsvrgb_pkg::HueWidth;
   localparam int unsigned RandomCount = 1500;
   localparam int unsigned IdleLimit   = 1000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned Scale       = 255;
   localparam int unsigned FirstWild   = 1536;

   localparam logic TypedResult = 1'b1;
   localparam logic Predicted   = 1'b0;

   typedef struct packed {
      hsvrgb_pkg::hsv_type colour;
      logic                known;
      hsvrgb_pkg::rgb_type typed;
   } directed_row_type;

   localparam int unsigned DirectedCount = 24;

   // The first rows carry results that can be worked out by hand: primaries,
   // yellow, grey, black, and the hues beyond the range that fall into the last sector.
   localparam directed_row_type DirectedRows [DirectedCount] = '{
      '{'{11'd0,    8'd255, 8'd255}, TypedResult, '{8'd255, 8'd0,   8'd0}},
      '{'{11'd512,  8'd255, 8'd255}, TypedResult, '{8'd0,   8'd255, 8'd0}},
      '{'{11'd1024, 8'd255, 8'd255}, TypedResult, '{8'd0,   8'd0,   8'd255}},
      '{'{11'd300,  8'd0,   8'd200}, TypedResult, '{8'd200, 8'd200, 8'd200}},
      '{'{11'd1535, 8'd0,   8'd255}, TypedResult, '{8'd255, 8'd255, 8'd255}},
      '{'{11'd777,  8'd200, 8'd0},   TypedResult, '{8'd0,   8'd0,   8'd0}},
      '{'{11'd2047, 8'd255, 8'd255}, TypedResult, '{8'd255, 8'd0,   8'd0}},
      '{'{11'd1536, 8'd255, 8'd255}, TypedResult, '{8'd255, 8'd0,   8'd255}},
      '{'{11'd255,  8'd255, 8'd255}, TypedResult, '{8'd255, 8'd255, 8'd0}},
      '{'{11'd256,  8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd767,  8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd768,  8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd1023, 8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd1279, 8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd1280, 8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd1535, 8'd255, 8'd255}, Predicted,   24'd0},
      '{'{11'd1791, 8'd128, 8'd77},  Predicted,   24'd0},
      '{'{11'd1792, 8'd1,   8'd254}, Predicted,   24'd0},
      '{'{11'd100,  8'd254, 8'd1},   Predicted,   24'd0},
      '{'{11'd600,  8'd128, 8'd128}, Predicted,   24'd0},
      '{'{11'd900,  8'd77,  8'd200}, Predicted,   24'd0},
      '{'{11'd1200, 8'd255, 8'd128}, Predicted,   24'd0},
      '{'{11'd1400, 8'd1,   8'd1},   Predicted,   24'd0},
      '{'{11'd2000, 8'd170, 8'd85},  Predicted,   24'd0}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   hsvrgb_pkg::hsv_type req_data;
   logic                rsp_valid;
   hsvrgb_pkg::rgb_type rsp_data;

   hsvrgb_pkg::rgb_type expected_colours [$];
   logic                drive_known;
   hsvrgb_pkg::rgb_type drive_typed;
   int unsigned         colours_sent;
   int unsigned         colours_beyond_range;
   int unsigned         colours_checked;
   int unsigned         mismatches;
   int unsigned         quiet_cycles = 0;

   hsv_to_rgb_integer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic hsvrgb_pkg::rgb_type convert_hsv(input hsvrgb_pkg::hsv_type colour);
      int unsigned sat;
      int unsigned val;
      int unsigned frac;
      logic [CW-1:0] p;
      logic [CW-1:0] q;
      logic [CW-1:0] t;
      logic [CW-1:0] v;
      hsvrgb_pkg::rgb_type result;
      sat  = 32'(colour.saturation);
      val  = 32'(colour.brightness);
      frac = 32'(colour.hue[CW-1:0]);
      v    = colour.brightness;
      p    = CW'(val * (Scale - sat) / Scale);
      q    = CW'(val * (Scale - sat * frac / Scale) / Scale);
      t    = CW'(val * (Scale - sat * (Scale - frac) / Scale) / Scale);
      case (colour.hue[HW-1:CW])
         hsvrgb_pkg::SectorRedToYellow: begin
            result = '{v, t, p};
         end
         hsvrgb_pkg::SectorYellowToGreen: begin
            result = '{q, v, p};
         end
         hsvrgb_pkg::SectorGreenToCyan: begin
            result = '{p, v, t};
         end
         hsvrgb_pkg::SectorCyanToBlue: begin
            result = '{p, q, v};
         end
         hsvrgb_pkg::SectorBlueToMagenta: begin
            result = '{t, p, v};
         end
         default: begin
            result = '{v, p, q};
         end
      endcase
      return result;
   endfunction

   task automatic report_mismatch(input string message);
      $display("%0t: %s", $time, message);
      mismatches++;
   endtask

   // Drives one colour from a falling edge, after random idle cycles when allowed, and holds it until the transfer.
   task automatic send_colour(input hsvrgb_pkg::hsv_type colour, input logic known,
                              input hsvrgb_pkg::rgb_type typed, input bit may_idle);
      @(negedge clock);
      while (may_idle && $urandom_range(99) < 23) begin
         start    <= 1'b0;
         req_data <= hsvrgb_pkg::hsv_type'(27'($urandom));
         @(negedge clock);
      end
      start       <= 1'b1;
      req_data    <= colour;
      drive_known  = known;
      drive_typed  = typed;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [CW-1:0] pick_channel();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         return '0;
      end else if (roll < 30) begin
         return hsvrgb_pkg::FullScale;
      end
      return CW'($urandom);
   endfunction

   always @(posedge clock) begin
      hsvrgb_pkg::rgb_type want;
      if (!reset && start && !busy) begin
         expected_colours.push_back(drive_known ? drive_typed : convert_hsv(req_data));
         colours_sent++;
         if (req_data.hue >= FirstWild) begin
            colours_beyond_range++;
         end
      end
      if (!reset && rsp_valid) begin
         if (expected_colours.size() == 0) begin
            report_mismatch("result arrived with no colour outstanding");
         end else begin
            want = expected_colours.pop_front();
            colours_checked++;
            if (rsp_data.red !== want.red) begin
               report_mismatch($sformatf("red is %0d, expected %0d",
                                         rsp_data.red, want.red));
            end
            if (rsp_data.green !== want.green) begin
               report_mismatch($sformatf("green is %0d, expected %0d",
                                         rsp_data.green, want.green));
            end
            if (rsp_data.blue !== want.blue) begin
               report_mismatch($sformatf("blue is %0d, expected %0d",
                                         rsp_data.blue, want.blue));
            end
         end
      end
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IdleLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      hsvrgb_pkg::hsv_type colour;
      int unsigned roll;
      colours_sent         = 0;
      colours_beyond_range = 0;
      colours_checked      = 0;
      mismatches           = 0;
      drive_known          = Predicted;
      drive_typed          = '0;
      reset                = 1'b1;
      start                = 1'b0;
      req_data             = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirectedCount; i++) begin
         send_colour(DirectedRows[i].colour, DirectedRows[i].known,
                     DirectedRows[i].typed, 1'b1);
      end

      // Let the pipeline run dry before the random part.
      @(negedge clock);
      start <= 1'b0;
      wait (expected_colours.size() == 0);

      for (int i = 0; i < RandomCount; i++) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            colour.hue = HW'($urandom_range(FirstWild - 1));
         end else if (roll < 95) begin
            colour.hue = HW'($urandom_range((1 << HW) - 1, FirstWild));
         end else begin
            colour.hue = {3'($urandom_range(7)),
                          ($urandom_range(1) ? hsvrgb_pkg::FullScale : 8'd0)};
         end
         colour.saturation = pick_channel();
         colour.brightness = pick_channel();
         if (i == RandomCount / 2) begin
            @(negedge clock);
            start <= 1'b0;
            wait (expected_colours.size() == 0);
         end
         // A stretch in the middle runs back to back with no gaps.
         send_colour(colour, Predicted, '0, !(i >= 400 && i < 700));
      end

      @(negedge clock);
      start <= 1'b0;
      wait (expected_colours.size() == 0);
      repeat (DrainCycles) @(posedge clock);

      $display("Converted %0d colours, %0d of them with hue past the last sector,",
               colours_sent, colours_beyond_range);
      $display("and checked %0d results with %0d mismatches.", colours_checked, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
